/* sv/msgseg_pkg.sv */
// msgseg_pkg: types and fixed constants shared by the packet segmenter files.
// No dependencies; compiled first.
package msgseg_pkg;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_WORD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_TYPE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_TYPE     = 2'd2;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [15:0] HEADER_RESET       = 16'h1A56;
   localparam logic [7:0]  PAYLOAD_TYPE_RESET = 8'h00;
   localparam logic [7:0]  END_TYPE_RESET     = 8'h01;

   // Report layout: header low, header high, type, size, then payload
   localparam int POS_HDR_LO = 0;
   localparam int POS_HDR_HI = 1;
   localparam int POS_TYPE   = 2;
   localparam int POS_SIZE   = 3;
   localparam int HDR_BYTES  = 4;

   typedef enum logic [0:0] {
      ST_FILL,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic take;      // input item accepted
      logic advance;   // result item taken
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic chunk_done;   // item on the input closes the chunk
      logic report_tail;  // current result item is the last of the report
   } ctl_sts_type;

endpackage

/* sv/msgseg_req_if.sv */
// msgseg_req_if: input channel, one message byte per item.
// Standalone; no package use.
interface msgseg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_byte;
   logic       message_last;

   modport source (output valid, output message_byte, output message_last, input ready);
   modport sink   (input valid, input message_byte, input message_last, output ready);
endinterface

/* sv/msgseg_rsp_if.sv */
// msgseg_rsp_if: result channel, one report byte per item.
// Standalone; no package use.
interface msgseg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] report_byte;
   logic       report_last;
   logic       message_done;

   modport source (output valid, output report_byte, output report_last,
                   output message_done, input ready);
   modport sink   (input valid, input report_byte, input report_last,
                   input message_done, output ready);
endinterface

/* sv/msgseg_ram.sv */
// msgseg_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module msgseg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 60
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/msgseg_ctrl.sv */
// msgseg_ctrl: two-state controller, collecting bytes or streaming a report.
// Uses msgseg_pkg (state, command and status types).
module msgseg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  msgseg_pkg::ctl_sts_type sts,
   output msgseg_pkg::ctl_cmd_type cmd
);

   msgseg_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msgseg_pkg::ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msgseg_pkg::ST_FILL: begin
            if (req_valid && sts.chunk_done) state_in = msgseg_pkg::ST_EMIT;
         end
         msgseg_pkg::ST_EMIT: begin
            if (rsp_ready && sts.report_tail) state_in = msgseg_pkg::ST_FILL;
         end
         default: state_in = msgseg_pkg::ST_FILL;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.take    = 1'b0;
      cmd.advance = 1'b0;
      case (state_ff)
         msgseg_pkg::ST_FILL: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         msgseg_pkg::ST_EMIT: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

/* sv/msgseg_dpath.sv */
// msgseg_dpath: config registers, chunk store, fill and byte counters, report mux.
// Uses msgseg_pkg and msgseg_ram.
module msgseg_dpath #(
   parameter int PAYLOAD_MAX  = 60,
   parameter int REPORT_BYTES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [msgseg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [msgseg_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  logic [7:0]                            message_byte,
   input  logic                                  message_last,
   input  msgseg_pkg::ctl_cmd_type               cmd,
   output msgseg_pkg::ctl_sts_type               sts,
   output logic [7:0]                            report_byte,
   output logic                                  report_last,
   output logic                                  message_done
);

   localparam int ADDR_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
   localparam int FILL_W = $clog2(PAYLOAD_MAX + 1);
   localparam int IDX_W  = $clog2(REPORT_BYTES);
   localparam int CNT_W  = IDX_W + 1;
   localparam int CMP_W  = ((CNT_W > FILL_W) ? CNT_W : FILL_W) + 1;

   logic [15:0]       header_ff;
   logic [7:0]        pay_type_ff;
   logic [7:0]        end_type_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              is_end_ff, is_end_in;

   logic [FILL_W:0]   fill_inc;
   logic [CNT_W-1:0]  rd_idx;
   logic [CMP_W-1:0]  rd_pos;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic [CMP_W-1:0]  idx_x;
   logic              tail;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff   <= msgseg_pkg::HEADER_RESET;
         pay_type_ff <= msgseg_pkg::PAYLOAD_TYPE_RESET;
         end_type_ff <= msgseg_pkg::END_TYPE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            msgseg_pkg::CSR_HEADER_WORD:  header_ff   <= csr_wr_data;
            msgseg_pkg::CSR_PAYLOAD_TYPE: pay_type_ff <= csr_wr_data[7:0];
            msgseg_pkg::CSR_END_TYPE:     end_type_ff <= csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   assign fill_inc        = {1'b0, fill_ff} + (FILL_W + 1)'(1);
   assign tail            = (idx_ff == IDX_W'(REPORT_BYTES - 1));
   assign sts.chunk_done  = message_last || (fill_inc == (FILL_W + 1)'(PAYLOAD_MAX));
   assign sts.report_tail = tail;

   always_comb begin
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      is_end_in = is_end_ff;
      if (cmd.take) begin
         fill_in   = fill_inc[FILL_W-1:0];
         idx_in    = '0;
         is_end_in = message_last;
      end else if (cmd.advance) begin
         idx_in = idx_ff + IDX_W'(1);
         if (tail) fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      is_end_ff <= is_end_in;
   end

   // read one byte ahead so the registered data lines up with idx_ff
   assign rd_idx = {1'b0, idx_ff} + CNT_W'(cmd.advance);
   assign rd_pos = CMP_W'(rd_idx) - CMP_W'(msgseg_pkg::HDR_BYTES);

   always_comb begin
      rd_addr = '0;
      if (CMP_W'(rd_idx) >= CMP_W'(msgseg_pkg::HDR_BYTES) &&
          rd_pos < CMP_W'(PAYLOAD_MAX)) begin
         rd_addr = rd_pos[ADDR_W-1:0];
      end
   end

   msgseg_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.take),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (message_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // report byte selection
   assign idx_x = CMP_W'(idx_ff);

   always_comb begin
      if (idx_x == CMP_W'(msgseg_pkg::POS_HDR_LO)) begin
         report_byte = header_ff[7:0];
      end else if (idx_x == CMP_W'(msgseg_pkg::POS_HDR_HI)) begin
         report_byte = header_ff[15:8];
      end else if (idx_x == CMP_W'(msgseg_pkg::POS_TYPE)) begin
         report_byte = is_end_ff ? end_type_ff : pay_type_ff;
      end else if (idx_x == CMP_W'(msgseg_pkg::POS_SIZE)) begin
         report_byte = 8'(fill_ff);
      end else if (idx_x < CMP_W'(fill_ff) + CMP_W'(msgseg_pkg::HDR_BYTES)) begin
         report_byte = rd_data;
      end else begin
         report_byte = 8'h00;
      end
   end

   assign report_last  = tail;
   assign message_done = tail && is_end_ff;

endmodule

/* sv/message_packet_segmenter_top.sv */
// message_packet_segmenter_top: top level of the packet segmenter.
// Uses msgseg_pkg, msgseg_req_if, msgseg_rsp_if, msgseg_ctrl and msgseg_dpath.
//
//  channel   direction  item                                   handshake
//  req_ch    in         message_byte, message_last             valid/ready
//  rsp_ch    out        report_byte, report_last, message_done valid/ready
//  csr_*     in         register index, write data             csr_wr_en only
//
// Flow: a byte not closing a chunk keeps the input ready. A byte that closes
//   a chunk (chunk full or last byte of the message) starts a report that
//   streams REPORT_BYTES items, one a cycle while rsp_ch.ready is high; the
//   input is held off until the final report item is taken.
// Reset: synchronous, active high; clears the controller and fill count and
//   loads the registers' reset values. The chunk store is not cleared.
// Stalls: rsp_ch.ready low holds the current report item and its store read.
module message_packet_segmenter_top #(
   parameter int PAYLOAD_MAX  = 60,
   parameter int REPORT_BYTES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   msgseg_req_if.sink                        req_ch,
   msgseg_rsp_if.source                      rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [msgseg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [msgseg_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   msgseg_pkg::ctl_cmd_type cmd;   // controller commands
   msgseg_pkg::ctl_sts_type sts;   // datapath status

   // controller: owns both handshakes
   msgseg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: store, counters, registers and report byte mux
   msgseg_dpath #(
      .PAYLOAD_MAX  (PAYLOAD_MAX),
      .REPORT_BYTES (REPORT_BYTES)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .message_byte (req_ch.message_byte),
      .message_last (req_ch.message_last),
      .cmd          (cmd),
      .sts          (sts),
      .report_byte  (rsp_ch.report_byte),
      .report_last  (rsp_ch.report_last),
      .message_done (rsp_ch.message_done)
   );

endmodule
